>>> rtl/assert_macros.svh
// Assertion macros used by the checker file of this project.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is asserted.
`define GMPS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define GMPS_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/gmps_pkg.sv
// Shared types and constants of the grid maximum path sum block.
// No dependencies.
`default_nettype none

package gmps_pkg;

    localparam int VALUE_W    = 16;
    localparam int SUM_W      = 21;
    localparam int COORD_W    = 4;
    localparam int CFG_W      = 5;
    localparam int OUT_DATA_W = 48;
    localparam int OP_W       = SUM_W + 1;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // register indexes of the configuration port
    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    typedef enum logic [1:0] {
        ALU_MAXADD,
        ALU_ADDEQ,
        ALU_SUBGE
    } alu_op_t;

    typedef struct packed {
        alu_op_t         op;
        logic [OP_W-1:0] a;
        logic [OP_W-1:0] b;
        logic [OP_W-1:0] c;
    } alu_req_t;

    typedef struct packed {
        logic [OP_W-1:0] res;
        logic            flag;
    } alu_rsp_t;

endpackage

`default_nettype wire

>>> rtl/gmps_alu.sv
// Shared arithmetic unit: saturating max-plus-add, add-and-compare, compare-and-subtract.
// Depends on gmps_pkg.
`default_nettype none

module gmps_alu (
    input  gmps_pkg::alu_req_t req,
    output gmps_pkg::alu_rsp_t rsp
);

    logic [gmps_pkg::OP_W-1:0] larger;
    logic [gmps_pkg::OP_W:0]   sum_wide;
    logic [gmps_pkg::OP_W:0]   chk_wide;

    always_comb
    begin
        larger   = (req.a > req.b) ? req.a : req.b;
        sum_wide = {1'b0, larger} + {1'b0, req.c};
        chk_wide = {1'b0, req.a} + {1'b0, req.c};
        rsp      = '0;
        case (req.op)
            gmps_pkg::ALU_MAXADD:
            begin
                // clamp to the widest representable path sum
                if (sum_wide > (gmps_pkg::OP_W + 1)'(gmps_pkg::SUM_MAX))
                    rsp.res = gmps_pkg::OP_W'(gmps_pkg::SUM_MAX);
                else
                    rsp.res = sum_wide[gmps_pkg::OP_W-1:0];
            end
            gmps_pkg::ALU_ADDEQ:
            begin
                rsp.flag = (chk_wide == {1'b0, req.b});
            end
            gmps_pkg::ALU_SUBGE:
            begin
                rsp.flag = (req.a >= req.b);
                rsp.res  = req.a - req.b;
            end
            default:
            begin
                rsp = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/grid_max_path_sum_traceback.sv
// Grid maximum path sum with traceback: top level.
// Depends on gmps_pkg and gmps_alu.
//
// Usage
//   Cells enter on the s_ group in row-major order, one item per cell. After the
//   last cell of a rows x cols grid the block walks back from the bottom-right
//   corner and sends rows + cols - 1 items on the m_ group, bottom-right first;
//   m_tlast marks the top-left cell. best_total is the same in every item of a run.
//   Configuration: cfg_we writes cfg_data into register cfg_index (0 rows, 1 cols).
//   Write only while idle; a new size applies from the next cell.
// Steps
//   A cell goes through two reads of the sum memory, then one pass through the
//   shared add/compare unit; s_tready is low in between. A path cell goes through
//   two sum memory reads and one compare, and waits out any output stall. After
//   reset and after every configuration write the block recomputes the grid
//   position with s_tready low.
// Reset and stalls
//   Reset clears the position, the cell count and the output register; the sizes
//   return to 16 x 16. Stored cells are undefined until written. While m_tready is
//   low the result waits in the output register and the walk holds.
`default_nettype none

module grid_max_path_sum_traceback #(
    parameter int MAX_ROWS = 16,
    parameter int MAX_COLS = 16
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // configuration port
    input  wire logic                             cfg_we,
    input  wire logic                             cfg_index,
    input  wire logic [gmps_pkg::CFG_W-1:0]       cfg_data,
    // cell input
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [gmps_pkg::VALUE_W-1:0]     s_tdata,    // [15:0] cell_value
    // path output
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [gmps_pkg::OUT_DATA_W-1:0]       m_tdata,    // [15:0] path_value,
                                                              // [19:16] path_row,
                                                              // [23:20] path_col,
                                                              // [44:24] best_total
    output logic                                  m_tlast     // top-left cell
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int SZR_W = $clog2(MAX_ROWS + 1);
    localparam int SZC_W = $clog2(MAX_COLS + 1);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int VW    = gmps_pkg::VALUE_W;
    localparam int SW    = gmps_pkg::SUM_W;
    localparam int OW    = gmps_pkg::OP_W;

    typedef enum logic [3:0] {
        ST_RC_TOTAL,
        ST_RC_WRAP,
        ST_RC_DIV,
        ST_IDLE,
        ST_UP,
        ST_LEFT,
        ST_SUM,
        ST_TB_RD0,
        ST_TB_RD1,
        ST_TB_OUT
    } state_t;

    function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r, input logic [CW-1:0] c);
        return AW'(AW'(r) * AW'(MAX_COLS)) + AW'(c);
    endfunction

    // control and payload registers
    state_t                        state_reg, state_next;
    logic [gmps_pkg::CFG_W-1:0]    rows_reg, rows_next;
    logic [gmps_pkg::CFG_W-1:0]    cols_reg, cols_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [CNT_W-1:0]              total_reg, total_next;
    logic [CNT_W-1:0]              div_reg, div_next;
    logic [RW-1:0]                 r_reg, r_next;
    logic [CW-1:0]                 c_reg, c_next;
    logic [RW-1:0]                 tr_reg, tr_next;
    logic [CW-1:0]                 tc_reg, tc_next;
    logic [VW-1:0]                 v_reg, v_next;
    logic [SW-1:0]                 up_reg, up_next;
    logic [SW-1:0]                 best_reg, best_next;
    logic [SW-1:0]                 cur_sum_reg, cur_sum_next;
    logic                          out_valid_reg, out_valid_next;
    logic [gmps_pkg::OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic                          out_last_reg, out_last_next;

    // memories
    logic [VW-1:0]                 grid_mem [DEPTH];
    logic [SW-1:0]                 sum_mem  [DEPTH];
    logic [VW-1:0]                 grid_rd_reg;
    logic [SW-1:0]                 sum_rd_reg;
    logic                          grid_re;
    logic                          sum_re;
    logic [AW-1:0]                 grid_rd_addr;
    logic [AW-1:0]                 sum_rd_addr;
    logic                          mem_we;
    logic [AW-1:0]                 mem_wr_addr;
    logic [SW-1:0]                 sum_wr_data;

    // effective sizes
    logic [SZR_W-1:0]              nr;
    logic [SZC_W-1:0]              nc;
    logic [SW-1:0]                 left_sum;
    logic                          accept;
    logic                          fin;

    gmps_pkg::alu_req_t            alu_req;
    gmps_pkg::alu_rsp_t            alu_rsp;

    gmps_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    // Clamp the size registers: zero acts as one, anything above the maximum as the maximum.
    always_comb
    begin
        if (rows_reg == '0)
            nr = SZR_W'(1);
        else if (int'(rows_reg) > MAX_ROWS)
            nr = SZR_W'(MAX_ROWS);
        else
            nr = SZR_W'(rows_reg);

        if (cols_reg == '0)
            nc = SZC_W'(1);
        else if (int'(cols_reg) > MAX_COLS)
            nc = SZC_W'(MAX_COLS);
        else
            nc = SZC_W'(cols_reg);
    end

    assign s_tready = (state_reg == ST_IDLE) && !cfg_we;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign fin      = (tr_reg == '0) && (tc_reg == '0);
    assign left_sum = (c_reg != '0) ? sum_rd_reg : '0;

    always_comb
    begin
        state_next     = state_reg;
        rows_next      = rows_reg;
        cols_next      = cols_reg;
        cnt_next       = cnt_reg;
        total_next     = total_reg;
        div_next       = div_reg;
        r_next         = r_reg;
        c_next         = c_reg;
        tr_next        = tr_reg;
        tc_next        = tc_reg;
        v_next         = v_reg;
        up_next        = up_reg;
        best_next      = best_reg;
        cur_sum_next   = cur_sum_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;

        grid_re        = 1'b0;
        sum_re         = 1'b0;
        grid_rd_addr   = '0;
        sum_rd_addr    = '0;
        mem_we         = 1'b0;
        mem_wr_addr    = cell_addr(r_reg, c_reg);
        sum_wr_data    = alu_rsp.res[SW-1:0];

        alu_req        = '0;
        alu_req.op     = gmps_pkg::ALU_SUBGE;

        case (state_reg)
            ST_RC_TOTAL:
            begin
                total_next = CNT_W'(nr) * CNT_W'(nc);
                state_next = ST_RC_WRAP;
            end
            ST_RC_WRAP:
            begin
                // a count that already fills the new grid starts a fresh one
                alu_req.a  = OW'(cnt_reg);
                alu_req.b  = OW'(total_reg);
                r_next     = '0;
                if (alu_rsp.flag)
                begin
                    cnt_next = '0;
                    div_next = '0;
                end
                else
                begin
                    div_next = cnt_reg;
                end
                state_next = ST_RC_DIV;
            end
            ST_RC_DIV:
            begin
                // take off one row per cycle until the column is left
                alu_req.a = OW'(div_reg);
                alu_req.b = OW'(nc);
                if (alu_rsp.flag)
                begin
                    div_next = alu_rsp.res[CNT_W-1:0];
                    r_next   = r_reg + RW'(1);
                end
                else
                begin
                    c_next     = div_reg[CW-1:0];
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    v_next     = s_tdata;
                    state_next = ST_UP;
                end
            end
            ST_UP:
            begin
                sum_re = 1'b1;
                if (r_reg != '0)
                    sum_rd_addr = cell_addr(r_reg - RW'(1), c_reg);
                state_next = ST_LEFT;
            end
            ST_LEFT:
            begin
                up_next = (r_reg != '0) ? sum_rd_reg : '0;
                sum_re  = 1'b1;
                if (c_reg != '0)
                    sum_rd_addr = cell_addr(r_reg, c_reg - CW'(1));
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                alu_req.op = gmps_pkg::ALU_MAXADD;
                alu_req.a  = OW'(up_reg);
                alu_req.b  = OW'(left_sum);
                alu_req.c  = OW'(v_reg);
                mem_we     = 1'b1;
                if (cnt_reg + CNT_W'(1) == total_reg)
                begin
                    // grid complete: start the walk at the bottom-right corner
                    cnt_next   = '0;
                    r_next     = '0;
                    c_next     = '0;
                    best_next  = alu_rsp.res[SW-1:0];
                    tr_next    = RW'(nr - SZR_W'(1));
                    tc_next    = CW'(nc - SZC_W'(1));
                    state_next = ST_TB_RD0;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                    if (SZC_W'(c_reg) + SZC_W'(1) == nc)
                    begin
                        c_next = '0;
                        r_next = r_reg + RW'(1);
                    end
                    else
                    begin
                        c_next = c_reg + CW'(1);
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_TB_RD0:
            begin
                grid_re      = 1'b1;
                sum_re       = 1'b1;
                grid_rd_addr = cell_addr(tr_reg, tc_reg);
                sum_rd_addr  = cell_addr(tr_reg, tc_reg);
                state_next   = ST_TB_RD1;
            end
            ST_TB_RD1:
            begin
                cur_sum_next = sum_rd_reg;
                sum_re       = 1'b1;
                if (tr_reg != '0)
                    sum_rd_addr = cell_addr(tr_reg - RW'(1), tc_reg);
                state_next = ST_TB_OUT;
            end
            ST_TB_OUT:
            begin
                // move up when the sum above plus this cell gives the stored sum
                alu_req.op = gmps_pkg::ALU_ADDEQ;
                alu_req.a  = OW'(sum_rd_reg);
                alu_req.b  = OW'(cur_sum_reg);
                alu_req.c  = OW'(grid_rd_reg);
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_last_next  = fin;
                    out_data_next  = {3'b000, best_reg,
                                      gmps_pkg::COORD_W'(tc_reg),
                                      gmps_pkg::COORD_W'(tr_reg),
                                      grid_rd_reg};
                    if (fin)
                        state_next = ST_IDLE;
                    else
                    begin
                        if (tr_reg == '0)
                            tc_next = tc_reg - CW'(1);
                        else if (tc_reg == '0)
                            tr_next = tr_reg - RW'(1);
                        else if (alu_rsp.flag)
                            tr_next = tr_reg - RW'(1);
                        else
                            tc_next = tc_reg - CW'(1);
                        state_next = ST_TB_RD0;
                    end
                end
            end
            default:
            begin
                state_next = ST_RC_TOTAL;
            end
        endcase

        // any size write forces a fresh position recompute
        if (cfg_we)
        begin
            case (cfg_index)
                gmps_pkg::REG_ROWS: rows_next = cfg_data;
                gmps_pkg::REG_COLS: cols_next = cfg_data;
                default:            rows_next = rows_reg;
            endcase
            state_next = ST_RC_TOTAL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RC_TOTAL;
            rows_reg      <= gmps_pkg::CFG_W'(16);
            cols_reg      <= gmps_pkg::CFG_W'(16);
            cnt_reg       <= '0;
            total_reg     <= '0;
            div_reg       <= '0;
            r_reg         <= '0;
            c_reg         <= '0;
            tr_reg        <= '0;
            tc_reg        <= '0;
            v_reg         <= '0;
            up_reg        <= '0;
            best_reg      <= '0;
            cur_sum_reg   <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rows_reg      <= rows_next;
            cols_reg      <= cols_next;
            cnt_reg       <= cnt_next;
            total_reg     <= total_next;
            div_reg       <= div_next;
            r_reg         <= r_next;
            c_reg         <= c_next;
            tr_reg        <= tr_next;
            tc_reg        <= tc_next;
            v_reg         <= v_next;
            up_reg        <= up_next;
            best_reg      <= best_next;
            cur_sum_reg   <= cur_sum_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
            out_last_reg  <= out_last_next;
        end
    end

    // cell value store
    always_ff @(posedge clk)
    begin
        if (mem_we)
            grid_mem[mem_wr_addr] <= v_reg;
        if (grid_re)
            grid_rd_reg <= grid_mem[grid_rd_addr];
    end

    // best sum store
    always_ff @(posedge clk)
    begin
        if (mem_we)
            sum_mem[mem_wr_addr] <= sum_wr_data;
        if (sum_re)
            sum_rd_reg <= sum_mem[sum_rd_addr];
    end

endmodule

`default_nettype wire

>>> rtl/gmps_checker.sv
// Port-level checks of the grid path block, bound to the top level.
// Depends on gmps_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module gmps_checker (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               s_tvalid,
    input wire logic                               s_tready,
    input wire logic                               m_tvalid,
    input wire logic                               m_tready,
    input wire logic [gmps_pkg::OUT_DATA_W-1:0]    m_tdata,
    input wire logic                               m_tlast
);

    // a stalled item holds
    `GMPS_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output item changed under stall")

    // each accepted cell drops s_tready, so no cell is taken back to back
    `GMPS_ASSERT(a_busy_after_cell, s_tvalid && s_tready |=> !s_tready, "cell accepted back to back")

    // the final item of a walk is the top-left cell
    `GMPS_ASSERT(a_last_origin, m_tvalid && m_tlast |-> m_tdata[23:16] == 8'h00, "last item not at the origin")

    // no earlier item of a walk sits at the origin
    `GMPS_ASSERT(a_origin_last, m_tvalid && !m_tlast |-> m_tdata[23:16] != 8'h00, "origin item without last")

    // nothing is offered in the cycle after reset has been seen
    `GMPS_ASSERT_RST(a_reset_quiet, !rst_n |=> !m_tvalid, "output valid during reset")

endmodule

bind grid_max_path_sum_traceback gmps_checker u_gmps_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire
